@@ rtl/cau_pkg.sv @@
// Shared types and constants for the complex arithmetic unit.
// Used by every module of the block; depends on nothing.
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LOW_BITS  = 32 - FRAC_BITS;
    localparam int QUO_BITS  = 32;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_NEG  = 3'd2,
        CMD_SCL  = 3'd3,
        CMD_MUL  = 3'd4,
        CMD_DIVR = 3'd5,
        CMD_CDIV = 3'd6,
        CMD_CONJ = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
        logic        neg;
        logic        ovf;
    } lane_t;

    typedef struct packed {
        logic              valid;
        logic              is_div;
        logic              dz;
        logic [63:0]       den;
        lane_t [1:0]       lane;
        logic [31:0]       byp_re;
        logic [31:0]       byp_im;
        logic              byp_sat;
    } cell_t;

endpackage

@@ rtl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit, top level. The pipeline has three front
// stages, a row of 32 division cells that each settle one quotient bit for
// both parts, and the output register. One request is taken every cycle
// unless a result waits; only then does the whole pipeline stall as one.
// Synchronous active-low reset empties the pipeline; no result is pending.
module complex_arithmetic_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_cmd,
    input  logic signed [31:0] s_a_re,
    input  logic signed [31:0] s_a_im,
    input  logic signed [31:0] s_b_re,
    input  logic signed [31:0] s_b_im,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_re,
    output logic signed [31:0] m_res_im,
    output logic               m_div_zero,
    output logic               m_saturated
);

    logic           en;
    cau_pkg::cell_t chain [cau_pkg::QUO_BITS+1];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    cau_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_a_re  (s_a_re),
        .s_a_im  (s_a_im),
        .s_b_re  (s_b_re),
        .s_b_im  (s_b_im),
        .cell_o  (chain[0])
    );

    for (genvar g = 0; g < cau_pkg::QUO_BITS; g++) begin : g_cell
        cau_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_i     (chain[g]),
            .d_o     (chain[g+1])
        );
    end

    cau_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .d_i         (chain[cau_pkg::QUO_BITS]),
        .m_valid     (m_valid),
        .m_res_re    (m_res_re),
        .m_res_im    (m_res_im),
        .m_div_zero  (m_div_zero),
        .m_saturated (m_saturated)
    );

endmodule

@@ rtl/cau_front.sv @@
// Front end: products, sums and saturation of the direct commands, and
// setup of the division lanes. Depends on cau_pkg.
module cau_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 s_valid,
    input  logic [2:0]           s_cmd,
    input  logic signed [31:0]   s_a_re,
    input  logic signed [31:0]   s_a_im,
    input  logic signed [31:0]   s_b_re,
    input  logic signed [31:0]   s_b_im,
    output cau_pkg::cell_t       cell_o
);

    logic                s1_valid_reg;
    cau_pkg::cmd_t       s1_cmd_reg;
    logic signed [31:0]  s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;
    logic signed [63:0]  s1_prr_reg, s1_pii_reg, s1_pri_reg, s1_pir_reg;
    logic signed [63:0]  s1_pbb_reg, s1_pcc_reg;

    logic                s2_valid_reg, s2_shift_reg, s2_div_reg, s2_dz_reg;
    logic signed [65:0]  s2_vre_reg, s2_vim_reg;
    logic [63:0]         s2_den_reg;

    logic signed [65:0]  vre_next, vim_next;
    logic [63:0]         den_next;
    logic                shift_next, div_next, dz_next;

    cau_pkg::cell_t      cell_reg, cell_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
            s1_cmd_reg   <= cau_pkg::cmd_t'(s_cmd);
            s1_ar_reg    <= s_a_re;
            s1_ai_reg    <= s_a_im;
            s1_br_reg    <= s_b_re;
            s1_bi_reg    <= s_b_im;
            s1_prr_reg   <= 64'(s_a_re) * 64'(s_b_re);
            s1_pii_reg   <= 64'(s_a_im) * 64'(s_b_im);
            s1_pri_reg   <= 64'(s_a_re) * 64'(s_b_im);
            s1_pir_reg   <= 64'(s_a_im) * 64'(s_b_re);
            s1_pbb_reg   <= 64'(s_b_re) * 64'(s_b_re);
            s1_pcc_reg   <= 64'(s_b_im) * 64'(s_b_im);
        end
    end

    always_comb begin
        vre_next   = 66'(s1_ar_reg);
        vim_next   = 66'(s1_ai_reg);
        den_next   = 64'(s1_pbb_reg) + 64'(s1_pcc_reg);
        shift_next = 1'b0;
        div_next   = 1'b0;
        dz_next    = 1'b0;
        unique case (s1_cmd_reg)
            cau_pkg::CMD_ADD: begin
                vre_next = 66'(s1_ar_reg) + 66'(s1_br_reg);
                vim_next = 66'(s1_ai_reg) + 66'(s1_bi_reg);
            end
            cau_pkg::CMD_SUB: begin
                vre_next = 66'(s1_ar_reg) - 66'(s1_br_reg);
                vim_next = 66'(s1_ai_reg) - 66'(s1_bi_reg);
            end
            cau_pkg::CMD_NEG: begin
                vre_next = -66'(s1_ar_reg);
                vim_next = -66'(s1_ai_reg);
            end
            cau_pkg::CMD_SCL: begin
                vre_next   = 66'(s1_prr_reg);
                vim_next   = 66'(s1_pir_reg);
                shift_next = 1'b1;
            end
            cau_pkg::CMD_MUL: begin
                vre_next   = 66'(s1_prr_reg) - 66'(s1_pii_reg);
                vim_next   = 66'(s1_pri_reg) + 66'(s1_pir_reg);
                shift_next = 1'b1;
            end
            cau_pkg::CMD_DIVR: begin
                vre_next = s1_br_reg[31] ? -66'(s1_ar_reg) : 66'(s1_ar_reg);
                vim_next = s1_br_reg[31] ? -66'(s1_ai_reg) : 66'(s1_ai_reg);
                den_next = 64'(s1_br_reg[31] ? -66'(s1_br_reg) : 66'(s1_br_reg));
                dz_next  = (s1_br_reg == 32'sd0);
                div_next = !dz_next;
            end
            cau_pkg::CMD_CDIV: begin
                vre_next = 66'(s1_prr_reg) + 66'(s1_pii_reg);
                vim_next = 66'(s1_pir_reg) - 66'(s1_pri_reg);
                dz_next  = (s1_br_reg == 32'sd0) && (s1_bi_reg == 32'sd0);
                div_next = !dz_next;
            end
            cau_pkg::CMD_CONJ: begin
                vim_next = -66'(s1_ai_reg);
            end
            default: begin
                vre_next = 66'(s1_ar_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
            s2_vre_reg   <= vre_next;
            s2_vim_reg   <= vim_next;
            s2_den_reg   <= den_next;
            s2_shift_reg <= shift_next;
            s2_div_reg   <= div_next;
            s2_dz_reg    <= dz_next;
        end
    end

    always_comb begin
        logic signed [65:0] v [2];
        logic [64:0]        mag, smag;
        logic [95:0]        wide;
        logic [31:0]        res [2];
        logic [31:0]        lim;
        logic               neg, sat;

        v[0]      = s2_vre_reg;
        v[1]      = s2_vim_reg;
        cell_next = '0;
        sat       = 1'b0;
        for (int i = 0; i < 2; i++) begin
            neg  = v[i][65];
            mag  = 65'(neg ? -v[i] : v[i]);
            smag = s2_shift_reg ? (mag >> cau_pkg::FRAC_BITS) : mag;
            lim  = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (smag > 65'(lim)) begin
                res[i] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                sat    = 1'b1;
            end else begin
                res[i] = neg ? -smag[31:0] : smag[31:0];
            end
            wide = {31'd0, mag} << cau_pkg::FRAC_BITS;
            cell_next.lane[i].rem = 64'(mag >> cau_pkg::LOW_BITS);
            cell_next.lane[i].low = wide[31:0];
            cell_next.lane[i].quo = '0;
            cell_next.lane[i].neg = neg;
            cell_next.lane[i].ovf = (mag >> cau_pkg::LOW_BITS) >= 65'(s2_den_reg);
        end
        cell_next.valid   = s2_valid_reg;
        cell_next.is_div  = s2_div_reg;
        cell_next.dz      = s2_dz_reg;
        cell_next.den     = s2_den_reg;
        cell_next.byp_re  = s2_dz_reg ? 32'd0 : res[0];
        cell_next.byp_im  = s2_dz_reg ? 32'd0 : res[1];
        cell_next.byp_sat = s2_dz_reg ? 1'b0 : sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_o = cell_reg;

endmodule

@@ rtl/cau_div_cell.sv @@
// One restoring-division cell: produces one quotient bit for both lanes.
// Depends on cau_pkg.
module cau_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  cau_pkg::cell_t  d_i,
    output cau_pkg::cell_t  d_o
);

    cau_pkg::cell_t d_reg, d_next;

    always_comb begin
        logic [64:0] trial;
        d_next = d_i;
        for (int i = 0; i < 2; i++) begin
            trial = {d_i.lane[i].rem, d_i.lane[i].low[31]};
            d_next.lane[i].low = {d_i.lane[i].low[30:0], 1'b0};
            if (trial >= {1'b0, d_i.den}) begin
                d_next.lane[i].rem = 64'(trial - {1'b0, d_i.den});
                d_next.lane[i].quo = {d_i.lane[i].quo[30:0], 1'b1};
            end else begin
                d_next.lane[i].rem = trial[63:0];
                d_next.lane[i].quo = {d_i.lane[i].quo[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.valid <= 1'b0;
        end else if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_o = d_reg;

endmodule

@@ rtl/cau_out.sv @@
// Output stage: signs and saturates the quotients or passes the direct
// result, and holds the result request. Depends on cau_pkg.
module cau_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  cau_pkg::cell_t     d_i,
    output logic               m_valid,
    output logic signed [31:0] m_res_re,
    output logic signed [31:0] m_res_im,
    output logic               m_div_zero,
    output logic               m_saturated
);

    logic        valid_reg, dz_reg, sat_reg;
    logic [31:0] re_reg, im_reg;
    logic [31:0] res_next [2];
    logic        sat_next;

    always_comb begin
        logic [31:0] lim;
        sat_next = 1'b0;
        for (int i = 0; i < 2; i++) begin
            lim = d_i.lane[i].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            if (d_i.lane[i].ovf || (d_i.lane[i].quo > lim)) begin
                res_next[i] = lim;
                sat_next    = 1'b1;
            end else begin
                res_next[i] = d_i.lane[i].neg ? -d_i.lane[i].quo : d_i.lane[i].quo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= d_i.valid;
            dz_reg    <= d_i.dz;
            re_reg    <= d_i.is_div ? res_next[0] : d_i.byp_re;
            im_reg    <= d_i.is_div ? res_next[1] : d_i.byp_im;
            sat_reg   <= d_i.is_div ? sat_next : d_i.byp_sat;
        end
    end

    assign m_valid     = valid_reg;
    assign m_res_re    = re_reg;
    assign m_res_im    = im_reg;
    assign m_div_zero  = dz_reg;
    assign m_saturated = sat_reg;

endmodule

@@ rtl/cau_checker.sv @@
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on complex_arithmetic_unit only through its ports.
module cau_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_res_re,
    input logic signed [31:0] m_res_im,
    input logic               m_div_zero,
    input logic               m_saturated
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_zero |-> m_res_re == 32'sd0 && m_res_im == 32'sd0 && !m_saturated)
        else $error("zero divisor result not cleared");

    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_res_re == 32'sh7FFF_FFFF || m_res_re == 32'sh8000_0000 ||
            m_res_im == 32'sh7FFF_FFFF || m_res_im == 32'sh8000_0000)
        else $error("saturation flag without a clamped part");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_res_re    (m_res_re),
    .m_res_im    (m_res_im),
    .m_div_zero  (m_div_zero),
    .m_saturated (m_saturated)
);

@@ verif/complex_arithmetic_unit_tb.sv @@
// Self-checking testbench for the complex arithmetic unit: directed and random requests,
// each result checked against a behavioral predictor of the Q16.16 complex ALU.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;

    typedef struct {
        cau_pkg::cmd_t      cmd;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } request_t;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               dz;
        logic               sat;
    } answer_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_cmd = '0;
    logic signed [31:0] s_a_re = '0;
    logic signed [31:0] s_a_im = '0;
    logic signed [31:0] s_b_re = '0;
    logic signed [31:0] s_b_im = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_res_re;
    logic signed [31:0] m_res_im;
    logic               m_div_zero;
    logic               m_saturated;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int       errors = 0;
    int       results_seen = 0;
    int       sat_seen = 0;
    int       dz_seen = 0;
    int       idle_cycles = 0;
    bit       quiet_phase = 1'b0;
    bit       hold_sender = 1'b0;
    bit       s_taken = 1'b0;

    complex_arithmetic_unit dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic signed [31:0] clamp(input logic signed [127:0] v, ref bit sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Signed division truncating toward zero; SystemVerilog / already does.
    function automatic logic signed [127:0] scaled_div(input logic signed [127:0] num,
                                                        input logic signed [127:0] den);
        return (num <<< cau_pkg::FRAC_BITS) / den;
    endfunction

    function automatic logic signed [127:0] unscale(input logic signed [127:0] v);
        return v / (128'sd1 <<< cau_pkg::FRAC_BITS);
    endfunction

    function automatic answer_t alu_predict(input request_t r);
        answer_t ans;
        bit sat = 1'b0;
        logic signed [127:0] ar, ai, br, bi, d;
        ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
        ans.dz = 1'b0;
        ans.re = '0;
        ans.im = '0;
        case (r.cmd)
            cau_pkg::CMD_ADD: begin
                ans.re = clamp(ar + br, sat);
                ans.im = clamp(ai + bi, sat);
            end
            cau_pkg::CMD_SUB: begin
                ans.re = clamp(ar - br, sat);
                ans.im = clamp(ai - bi, sat);
            end
            cau_pkg::CMD_NEG: begin
                ans.re = clamp(-ar, sat);
                ans.im = clamp(-ai, sat);
            end
            cau_pkg::CMD_SCL: begin
                ans.re = clamp(unscale(ar * br), sat);
                ans.im = clamp(unscale(ai * br), sat);
            end
            cau_pkg::CMD_MUL: begin
                ans.re = clamp(unscale(ar * br - ai * bi), sat);
                ans.im = clamp(unscale(ar * bi + ai * br), sat);
            end
            cau_pkg::CMD_DIVR: begin
                if (br == 0) ans.dz = 1'b1;
                else begin
                    ans.re = clamp(scaled_div(ar, br), sat);
                    ans.im = clamp(scaled_div(ai, br), sat);
                end
            end
            cau_pkg::CMD_CDIV: begin
                d = br * br + bi * bi;
                if (d == 0) ans.dz = 1'b1;
                else begin
                    ans.re = clamp(scaled_div(ar * br + ai * bi, d), sat);
                    ans.im = clamp(scaled_div(ai * br - ar * bi, d), sat);
                end
            end
            default: begin
                ans.re = clamp(ar, sat);
                ans.im = clamp(-ai, sat);
            end
        endcase
        ans.sat = sat;
        return ans;
    endfunction

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return $signed($urandom_range(0, 15)) - 8;
            4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            5: return $signed($urandom_range(0, 32'h7ffffff)) - 32'sh4000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(input cau_pkg::cmd_t cmd, input logic signed [31:0] a_re,
                                 input logic signed [31:0] a_im,
                                 input logic signed [31:0] b_re,
                                 input logic signed [31:0] b_im);
        request_t r;
        r.cmd = cmd; r.a_re = a_re; r.a_im = a_im; r.b_re = b_re; r.b_im = b_im;
        pending_requests.push_back(r);
    endtask

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_taken) begin
                if (pending_requests.size() != 0 && !hold_sender &&
                    (quiet_phase || $urandom_range(0, 99) >= 16)) begin
                    request_t r;
                    r = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= r.cmd;
                    s_a_re <= r.a_re;
                    s_a_im <= r.a_im;
                    s_b_re <= r.b_re;
                    s_b_im <= r.b_im;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= quiet_phase || $urandom_range(0, 99) >= 16;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                request_t r;
                r.cmd = cau_pkg::cmd_t'(s_cmd);
                r.a_re = s_a_re; r.a_im = s_a_im; r.b_re = s_b_re; r.b_im = s_b_im;
                expected_answers.push_back(alu_predict(r));
            end
            if (m_valid && m_ready) begin
                answer_t exp_ans;
                results_seen++;
                if (expected_answers.size() == 0) begin
                    $display("%0t: result with no request outstanding: re=%h im=%h",
                             $time, m_res_re, m_res_im);
                    errors++;
                end else begin
                    exp_ans = expected_answers.pop_front();
                    if (exp_ans.sat) sat_seen++;
                    if (exp_ans.dz) dz_seen++;
                    if (m_res_re !== exp_ans.re || m_res_im !== exp_ans.im ||
                        m_div_zero !== exp_ans.dz || m_saturated !== exp_ans.sat) begin
                        $display("%0t: mismatch expected re=%h im=%h dz=%b sat=%b",
                                 $time, exp_ans.re, exp_ans.im, exp_ans.dz, exp_ans.sat);
                        $display("%0t:          actual   re=%h im=%h dz=%b sat=%b",
                                 $time, m_res_re, m_res_im, m_div_zero, m_saturated);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding.",
                         expected_answers.size());
                $display("complex_arithmetic_unit_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        logic signed [31:0] MAXV, MINV, ONE;
        MAXV = 32'sh7fffffff; MINV = 32'sh80000000; ONE = 32'sh00010000;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        queue_request(cau_pkg::CMD_ADD, MAXV, MINV, ONE, -ONE);
        queue_request(cau_pkg::CMD_ADD, MINV, MAXV, MINV, MAXV);
        queue_request(cau_pkg::CMD_SUB, MINV, MAXV, ONE, -ONE);
        queue_request(cau_pkg::CMD_SUB, 32'sd5, -32'sd7, 32'sd3, 32'sd9);
        queue_request(cau_pkg::CMD_NEG, MINV, MAXV, 0, 0);
        queue_request(cau_pkg::CMD_NEG, -ONE, 0, MAXV, MINV);
        queue_request(cau_pkg::CMD_SCL, MAXV, MINV, ONE, 0);
        queue_request(cau_pkg::CMD_SCL, MAXV, MINV, MAXV, 0);
        queue_request(cau_pkg::CMD_SCL, -32'sd3, 32'sd3, 32'sd1, 0);
        queue_request(cau_pkg::CMD_MUL, ONE, ONE, ONE, -ONE);
        queue_request(cau_pkg::CMD_MUL, MINV, MINV, MINV, MINV);
        queue_request(cau_pkg::CMD_MUL, MAXV, MINV, MAXV, MAXV);
        queue_request(cau_pkg::CMD_DIVR, ONE, -ONE, 0, MAXV);
        queue_request(cau_pkg::CMD_DIVR, MAXV, MINV, 32'sd1, 0);
        queue_request(cau_pkg::CMD_DIVR, MINV, MAXV, -32'sd1, 0);
        queue_request(cau_pkg::CMD_DIVR, -32'sd7, 32'sd7, 32'sd3, 0);
        queue_request(cau_pkg::CMD_CDIV, ONE, ONE, 0, 0);
        queue_request(cau_pkg::CMD_CDIV, ONE, -ONE, ONE, ONE);
        queue_request(cau_pkg::CMD_CDIV, MAXV, MINV, 32'sd1, 32'sd1);
        queue_request(cau_pkg::CMD_CDIV, MINV, MINV, MINV, MINV);
        queue_request(cau_pkg::CMD_CDIV, 32'sd5, -32'sd3, MAXV, -32'sd1);
        queue_request(cau_pkg::CMD_CONJ, MAXV, MINV, 0, 0);
        queue_request(cau_pkg::CMD_CONJ, MINV, MAXV, ONE, ONE);

        // Let the pipeline drain completely before the random traffic starts.
        wait (pending_requests.size() == 0);
        hold_sender = 1'b1;
        wait (expected_answers.size() == 0 && !s_valid);
        hold_sender = 1'b0;

        for (int i = 0; i < 1150; i++) begin
            logic signed [31:0] br, bi;
            br = pick_operand();
            bi = pick_operand();
            if ($urandom_range(0, 19) == 0) br = 0;
            if ($urandom_range(0, 29) == 0) bi = 0;
            queue_request(cau_pkg::cmd_t'($urandom_range(0, 7)), pick_operand(),
                          pick_operand(), br, bi);
            if (i == 400) begin
                wait (pending_requests.size() == 0);
                quiet_phase = 1'b1;
            end
            if (i == 700) begin
                wait (pending_requests.size() == 0);
                quiet_phase = 1'b0;
            end
        end

        wait (pending_requests.size() == 0 && !s_valid && expected_answers.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d results, %0d saturated and %0d divide-by-zero,", results_seen,
                 sat_seen, dz_seen);
        $display("covering every command with extreme, small and random operands.");
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("complex_arithmetic_unit_tb OK");
        end else begin
            $display("complex_arithmetic_unit_tb NOT OK");
        end
        $finish;
    end
endmodule
